### src/epm_pkg.sv
`default_nettype none

package epm_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [2:0] REG_STOP_BAND     = 3'd3;
    localparam logic [2:0] REG_SETTLE_TICKS  = 3'd4;
    localparam logic [2:0] REG_DUTY_LIMIT    = 3'd5;

    localparam logic [27:0] PROP_GAIN_RESET     = 28'd838861;
    localparam logic [29:0] INTEGRAL_GAIN_RESET = 30'd4295;
    localparam logic [27:0] DERIV_GAIN_RESET    = 28'd0;
    localparam logic [7:0]  STOP_BAND_RESET     = 8'd2;
    localparam logic [15:0] SETTLE_TICKS_RESET  = 16'd200;
    localparam logic [9:0]  DUTY_LIMIT_RESET    = 10'd280;

    localparam logic signed [31:0] ERR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ERR_MIN = -32'sh8000_0000;
    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = -48'sh8000_0000_0000;
    localparam logic [15:0]        RUN_MAX = 16'hFFFF;

    typedef struct packed {
        logic pid_en;
        logic moving;
        logic rejected;
        logic settled;
    } flags_t;

endpackage

`default_nettype wire

### src/epm_output_path.sv
`default_nettype none

module epm_output_path (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s1_valid,
    output logic                     s1_ready,
    input  wire logic signed [31:0]  err,
    input  wire logic signed [32:0]  derr,
    input  wire logic signed [47:0]  sum,
    input  wire epm_pkg::flags_t     flags,
    input  wire logic [27:0]         prop_gain,
    input  wire logic [29:0]         integral_gain,
    input  wire logic [27:0]         deriv_gain,
    input  wire logic [9:0]          duty_limit,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [9:0]               duty,
    output logic                     direction,
    output logic                     moving,
    output logic                     start_rejected,
    output logic                     settled
);

    logic                   s2_valid_reg;
    logic signed [60:0]     p_prod_reg;
    logic signed [61:0]     d_prod_reg;
    logic signed [54:0]     ih_prod_reg;
    logic [53:0]            il_prod_reg;
    epm_pkg::flags_t        s2_flags_reg;

    logic                   out_valid_reg;
    logic [9:0]             duty_reg;
    logic                   direction_reg;
    logic                   moving_reg;
    logic                   rejected_reg;
    logic                   settled_reg;

    logic                   adv_out;
    logic                   adv_s2;

    logic signed [60:0]     p_prod_next;
    logic signed [61:0]     d_prod_next;
    logic signed [54:0]     ih_prod_next;
    logic [53:0]            il_prod_next;

    logic [80:0]            total;
    logic [80:0]            total_abs;
    logic [50:0]            mag;
    logic [9:0]             duty_next;
    logic                   direction_next;

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_s2   = !s2_valid_reg || adv_out;
    assign s1_ready = adv_s2;

    // partial products, integral split into signed high and unsigned low halves
    assign p_prod_next  = $signed({1'b0, prop_gain}) * err;
    assign d_prod_next  = $signed({1'b0, deriv_gain}) * derr;
    assign ih_prod_next = $signed({1'b0, integral_gain}) * $signed(sum[47:24]);
    assign il_prod_next = integral_gain * sum[23:0];

    always_comb
    begin
        total = {{14{p_prod_reg[60]}}, p_prod_reg, 6'd0}
              + {{13{d_prod_reg[61]}}, d_prod_reg, 6'd0}
              + {{2{ih_prod_reg[54]}}, ih_prod_reg, 24'd0}
              + {27'd0, il_prod_reg};
        total_abs = total[80] ? (~total + 81'd1) : total;
        // truncation toward zero of the q30 sum
        mag = total_abs[80:30];
        duty_next = (mag > {41'd0, duty_limit}) ? duty_limit : mag[9:0];
        direction_next = total[80] && (mag != 51'd0);
        if (!s2_flags_reg.pid_en)
        begin
            duty_next      = 10'd0;
            direction_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s2)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s2)
        begin
            p_prod_reg   <= p_prod_next;
            d_prod_reg   <= d_prod_next;
            ih_prod_reg  <= ih_prod_next;
            il_prod_reg  <= il_prod_next;
            s2_flags_reg <= flags;
        end
        if (adv_out)
        begin
            duty_reg      <= duty_next;
            direction_reg <= direction_next;
            moving_reg    <= s2_flags_reg.moving;
            rejected_reg  <= s2_flags_reg.rejected;
            settled_reg   <= s2_flags_reg.settled;
        end
    end

    assign out_valid      = out_valid_reg;
    assign duty           = duty_reg;
    assign direction      = direction_reg;
    assign moving         = moving_reg;
    assign start_rejected = rejected_reg;
    assign settled        = settled_reg;

endmodule

`default_nettype wire

### src/encoder_position_pid_move.sv
// Position move controller with PID law on the encoder count.
// Input channel: in_valid / in_stall carry op, encoder_count and target; a beat
// is taken at a rising edge with in_valid high and in_stall low. Op tick runs
// the control law, op start begins a move (rejected while one runs), op abort
// ends it.
// Output channel: out_valid / out_stall carry duty, direction, moving,
// start_rejected and settled, one result beat for every input beat, in order.
// The result is registered at acceptance, then in the product register, then in
// the output register. Throughput: one beat per cycle while out_stall is low; the
// state update for a beat happens in the cycle it is taken, the three gain multiplies
// and the wide sum follow in two further register stages.
// When the receiver stalls the result holds and the stages behind it keep
// filling; in_stall rises once all three stages hold a beat.
// Configuration: cfg_write with cfg_index and cfg_data, taken at a rising edge; the
// user must write only while the block is idle, which the block does not enforce.
// Reset: gains and limits return to their defaults, the move state clears and
// no beat is in flight.
`default_nettype none

module encoder_position_pid_move (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] encoder_count,
    input  wire logic signed [23:0] target,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [9:0]              duty,
    output logic                    direction,
    output logic                    moving,
    output logic                    start_rejected,
    output logic                    settled,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [29:0]        cfg_data
);

    logic [27:0]            prop_gain_reg;
    logic [29:0]            integral_gain_reg;
    logic [27:0]            deriv_gain_reg;
    logic [7:0]             stop_band_reg;
    logic [15:0]            settle_ticks_reg;
    logic [9:0]             duty_limit_reg;

    logic [31:0]            position_reg;
    logic [31:0]            position_next;
    logic [31:0]            goal_position_reg;
    logic [31:0]            goal_position_next;
    logic signed [47:0]     error_sum_reg;
    logic signed [47:0]     error_sum_next;
    logic signed [31:0]     last_error_reg;
    logic signed [31:0]     last_error_next;
    logic [31:0]            last_count_reg;
    logic [31:0]            last_count_next;
    logic [15:0]            on_target_run_reg;
    logic [15:0]            on_target_run_next;
    logic                   move_active_reg;
    logic                   move_active_next;

    logic                   s1_valid_reg;
    logic signed [31:0]     s1_err_reg;
    logic signed [32:0]     s1_derr_reg;
    logic signed [47:0]     s1_sum_reg;
    epm_pkg::flags_t        s1_flags_reg;
    epm_pkg::flags_t        flags_next;

    logic                   s1_ready;
    logic                   adv_s1;
    logic                   accept;

    logic [31:0]            pos_tick;
    logic signed [32:0]     diff;
    logic signed [31:0]     err;
    logic signed [38:0]     err_ext;
    logic signed [38:0]     sum_inc;
    logic signed [48:0]     sum_wide;
    logic signed [47:0]     sum_sat;
    logic signed [32:0]     derr;
    logic signed [32:0]     err33;
    logic signed [32:0]     neg33;
    logic signed [32:0]     band33;
    logic                   opposed;
    logic                   on_target;
    logic [15:0]            run_inc;
    logic                   run_done;

    assign adv_s1   = !s1_valid_reg || s1_ready;
    assign in_stall = !adv_s1;
    assign accept   = in_valid && adv_s1;

    always_comb
    begin
        pos_tick = position_reg - $unsigned(encoder_count) + last_count_reg;
        diff = $signed({goal_position_reg[31], goal_position_reg})
             - $signed({pos_tick[31], pos_tick});
        if (diff[32] != diff[31])
        begin
            err = diff[32] ? epm_pkg::ERR_MIN : epm_pkg::ERR_MAX;
        end
        else
        begin
            err = diff[31:0];
        end

        opposed = (error_sum_reg < 0 && err > 0) || (error_sum_reg > 0 && err < 0);
        err_ext = {{7{err[31]}}, err};
        // times one hundred as 64 + 32 + 4
        sum_inc = opposed ? ((err_ext <<< 6) + (err_ext <<< 5) + (err_ext <<< 2)) : err_ext;
        sum_wide = {error_sum_reg[47], error_sum_reg} + {{10{sum_inc[38]}}, sum_inc};
        if (sum_wide[48] != sum_wide[47])
        begin
            sum_sat = sum_wide[48] ? epm_pkg::SUM_MIN : epm_pkg::SUM_MAX;
        end
        else
        begin
            sum_sat = sum_wide[47:0];
        end

        derr   = {err[31], err} - {last_error_reg[31], last_error_reg};
        err33  = {err[31], err};
        neg33  = -err33;
        band33 = $signed({25'd0, stop_band_reg});
        on_target = (err33 < band33) && (neg33 < band33);
        run_inc  = (on_target_run_reg == epm_pkg::RUN_MAX) ? on_target_run_reg
                                                           : on_target_run_reg + 16'd1;
        run_done = run_inc >= settle_ticks_reg;

        position_next      = position_reg;
        goal_position_next = goal_position_reg;
        error_sum_next     = error_sum_reg;
        last_error_next    = last_error_reg;
        last_count_next    = last_count_reg;
        on_target_run_next = on_target_run_reg;
        move_active_next   = move_active_reg;
        flags_next         = '0;

        if (accept)
        begin
            unique case (op)
                epm_pkg::OP_START:
                begin
                    if (move_active_reg)
                    begin
                        flags_next.rejected = 1'b1;
                    end
                    else
                    begin
                        goal_position_next = {{8{target[23]}}, target};
                        position_next      = 32'd0;
                        error_sum_next     = '0;
                        on_target_run_next = 16'd0;
                        move_active_next   = 1'b1;
                    end
                end
                epm_pkg::OP_ABORT:
                begin
                    move_active_next   = 1'b0;
                    position_next      = 32'd0;
                    error_sum_next     = '0;
                    on_target_run_next = 16'd0;
                end
                epm_pkg::OP_TICK:
                begin
                    last_count_next = $unsigned(encoder_count);
                    if (move_active_reg)
                    begin
                        position_next     = pos_tick;
                        error_sum_next    = sum_sat;
                        last_error_next   = err;
                        flags_next.pid_en = 1'b1;
                        if (on_target)
                        begin
                            on_target_run_next = run_inc;
                            if (run_done)
                            begin
                                move_active_next   = 1'b0;
                                position_next      = 32'd0;
                                error_sum_next     = '0;
                                on_target_run_next = 16'd0;
                                flags_next.pid_en  = 1'b0;
                                flags_next.settled = 1'b1;
                            end
                        end
                        else
                        begin
                            on_target_run_next = 16'd0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        flags_next.moving = move_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= epm_pkg::PROP_GAIN_RESET;
            integral_gain_reg <= epm_pkg::INTEGRAL_GAIN_RESET;
            deriv_gain_reg    <= epm_pkg::DERIV_GAIN_RESET;
            stop_band_reg     <= epm_pkg::STOP_BAND_RESET;
            settle_ticks_reg  <= epm_pkg::SETTLE_TICKS_RESET;
            duty_limit_reg    <= epm_pkg::DUTY_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                epm_pkg::REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[27:0];
                epm_pkg::REG_INTEGRAL_GAIN: integral_gain_reg <= cfg_data;
                epm_pkg::REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[27:0];
                epm_pkg::REG_STOP_BAND:     stop_band_reg     <= cfg_data[7:0];
                epm_pkg::REG_SETTLE_TICKS:  settle_ticks_reg  <= cfg_data[15:0];
                epm_pkg::REG_DUTY_LIMIT:    duty_limit_reg    <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= 32'd0;
            goal_position_reg <= 32'd0;
            error_sum_reg     <= '0;
            last_error_reg    <= '0;
            last_count_reg    <= 32'd0;
            on_target_run_reg <= 16'd0;
            move_active_reg   <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            position_reg      <= position_next;
            goal_position_reg <= goal_position_next;
            error_sum_reg     <= error_sum_next;
            last_error_reg    <= last_error_next;
            last_count_reg    <= last_count_next;
            on_target_run_reg <= on_target_run_next;
            move_active_reg   <= move_active_next;
            if (adv_s1)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    // values for the multiply stage
    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_err_reg   <= err;
            s1_derr_reg  <= derr;
            s1_sum_reg   <= sum_sat;
            s1_flags_reg <= flags_next;
        end
    end

    epm_output_path u_output_path (
        .clk            (clk),
        .rst_n          (rst_n),
        .s1_valid       (s1_valid_reg),
        .s1_ready       (s1_ready),
        .err            (s1_err_reg),
        .derr           (s1_derr_reg),
        .sum            (s1_sum_reg),
        .flags          (s1_flags_reg),
        .prop_gain      (prop_gain_reg),
        .integral_gain  (integral_gain_reg),
        .deriv_gain     (deriv_gain_reg),
        .duty_limit     (duty_limit_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty           (duty),
        .direction      (direction),
        .moving         (moving),
        .start_rejected (start_rejected),
        .settled        (settled)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == epm_pkg::OP_START && !move_active_reg |=> move_active_reg)
        else $error("start from idle did not begin a move");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && op == epm_pkg::OP_ABORT |=> !move_active_reg)
        else $error("abort left a move running");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_rejected |-> moving)
        else $error("start rejected without a running move");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moving |-> duty == 10'd0 && !direction)
        else $error("drive output while no move runs");

endmodule

`default_nettype wire

### sim/epm_checker.sv
module epm_checker
    import epm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         op,
    input  wire logic signed [31:0] encoder_count,
    input  wire logic signed [23:0] target,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [9:0]         duty,
    input  wire logic               direction,
    input  wire logic               moving,
    input  wire logic               start_rejected,
    input  wire logic               settled,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [29:0]        cfg_data,
    output int                      fail_count,
    output int                      pending_count
);

    typedef struct packed {
        logic [9:0] duty;
        logic       direction;
        logic       moving;
        logic       start_rejected;
        logic       settled;
    } motor_cmd_t;

    motor_cmd_t motor_cmds[$];
    motor_cmd_t want_cmd;
    motor_cmd_t next_cmd;

    logic [27:0] kp_reg;
    logic [29:0] ki_reg;
    logic [27:0] kd_reg;
    logic [7:0]  band_reg;
    logic [15:0] settle_reg;
    logic [9:0]  duty_lim_reg;

    logic [31:0]        position;
    logic [31:0]        goal_position;
    logic [31:0]        last_count;
    logic signed [47:0] error_sum;
    logic signed [31:0] last_error;
    logic [15:0]        on_target_run;
    logic               move_active;

    task automatic clear_move();
        move_active   = 1'b0;
        position      = '0;
        error_sum     = '0;
        on_target_run = '0;
    endtask

    task automatic control_step(input logic [1:0] op_in, input logic [31:0] count,
                                input logic [23:0] tgt, output motor_cmd_t r);
        logic signed [32:0] err_wide;
        logic signed [31:0] err;
        logic signed [95:0] err_x, last_x, sum_x, sum_next, band_x;
        logic signed [95:0] kp_x, ki_x, kd_x, pid_sum;
        logic [95:0]        mag;
        logic               opposed;
        r = '0;
        case (op_in)
            OP_START:
            begin
                if (move_active)
                begin
                    r.start_rejected = 1'b1;
                end
                else
                begin
                    goal_position = {{8{tgt[23]}}, tgt};
                    position      = '0;
                    error_sum     = '0;
                    on_target_run = '0;
                    move_active   = 1'b1;
                end
            end
            OP_ABORT:
            begin
                clear_move();
            end
            OP_TICK:
            begin
                if (move_active)
                begin
                    position = position - (count - last_count);
                    err_wide = $signed({goal_position[31], goal_position})
                             - $signed({position[31], position});
                    if (err_wide > ERR_MAX)
                        err = ERR_MAX;
                    else if (err_wide < ERR_MIN)
                        err = ERR_MIN;
                    else
                        err = err_wide[31:0];
                    err_x = err;
                    opposed = (error_sum < 0 && err > 0) || (error_sum > 0 && err < 0);
                    sum_next = error_sum;
                    sum_next = sum_next + (opposed ? err_x * 100 : err_x);
                    if (sum_next > SUM_MAX)
                        sum_next = SUM_MAX;
                    else if (sum_next < SUM_MIN)
                        sum_next = SUM_MIN;
                    error_sum = sum_next[47:0];
                    sum_x  = error_sum;
                    last_x = last_error;
                    kp_x   = kp_reg;
                    ki_x   = ki_reg;
                    kd_x   = kd_reg;
                    // q30 sum, truncated toward zero below
                    pid_sum = ((kp_x * err_x) <<< 6) + ((kd_x * (err_x - last_x)) <<< 6)
                            + ki_x * sum_x;
                    last_error = err;
                    if (pid_sum < 0)
                    begin
                        mag = -pid_sum;
                        mag = mag >> 30;
                        r.direction = (mag != '0);
                    end
                    else
                    begin
                        mag = pid_sum;
                        mag = mag >> 30;
                    end
                    r.duty = (mag > duty_lim_reg) ? duty_lim_reg : mag[9:0];
                    band_x = band_reg;
                    if (err_x < band_x && -err_x < band_x)
                    begin
                        if (on_target_run != RUN_MAX)
                            on_target_run = on_target_run + 16'd1;
                        if (on_target_run >= settle_reg)
                        begin
                            clear_move();
                            r.settled   = 1'b1;
                            r.duty      = '0;
                            r.direction = 1'b0;
                        end
                    end
                    else
                    begin
                        on_target_run = '0;
                    end
                end
                last_count = count;
            end
            default:
            begin
            end
        endcase
        r.moving = move_active;
    endtask

    task automatic report_field(input string name, input logic [9:0] want_v,
                                input logic [9:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        = PROP_GAIN_RESET;
            ki_reg        = INTEGRAL_GAIN_RESET;
            kd_reg        = DERIV_GAIN_RESET;
            band_reg      = STOP_BAND_RESET;
            settle_reg    = SETTLE_TICKS_RESET;
            duty_lim_reg  = DUTY_LIMIT_RESET;
            position      = '0;
            goal_position = '0;
            last_count    = '0;
            error_sum     = '0;
            last_error    = '0;
            on_target_run = '0;
            move_active   = 1'b0;
            motor_cmds.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (motor_cmds.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, duty %0d", $time, duty);
                end
                else
                begin
                    want_cmd = motor_cmds.pop_front();
                    report_field("duty", want_cmd.duty, duty);
                    report_field("direction", 10'(want_cmd.direction), 10'(direction));
                    report_field("moving", 10'(want_cmd.moving), 10'(moving));
                    report_field("start_rejected", 10'(want_cmd.start_rejected),
                                 10'(start_rejected));
                    report_field("settled", 10'(want_cmd.settled), 10'(settled));
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:     kp_reg       = cfg_data[27:0];
                    REG_INTEGRAL_GAIN: ki_reg       = cfg_data[29:0];
                    REG_DERIV_GAIN:    kd_reg       = cfg_data[27:0];
                    REG_STOP_BAND:     band_reg     = cfg_data[7:0];
                    REG_SETTLE_TICKS:  settle_reg   = cfg_data[15:0];
                    REG_DUTY_LIMIT:    duty_lim_reg = cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                control_step(op, encoder_count, target, next_cmd);
                motor_cmds.push_back(next_cmd);
            end
            pending_count = motor_cmds.size();
        end
    end

endmodule

### sim/tb.sv
module tb;
    import epm_pkg::*;

    localparam logic [1:0] OP_SPARE    = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         RANDOM_END  = 1320;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [1:0]         op             = OP_TICK;
    logic signed [31:0] encoder_count  = '0;
    logic signed [23:0] target         = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [9:0]         duty;
    logic               direction;
    logic               moving;
    logic               start_rejected;
    logic               settled;
    logic               cfg_write      = 1'b0;
    logic [2:0]         cfg_index      = REG_PROP_GAIN;
    logic [29:0]        cfg_data       = '0;
    int                 fail_count;
    int                 pending_count;

    int          beats_sent = 0;
    int          burst_left = 0;
    logic [31:0] enc        = '0;
    int          band_cfg   = STOP_BAND_RESET;
    int          settle_cfg = SETTLE_TICKS_RESET;
    int          stall_left = 0;
    int          stall_mode = 0;

    encoder_position_pid_move dut (.*);

    epm_checker u_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver back-pressure, independent of the sender
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 3) ? $urandom_range(1, 15) : $urandom_range(10, 80);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ($urandom_range(0, 7) == 0);
            default: out_stall <= 1'b1;
        endcase
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_beat(input logic [1:0] o, input logic [31:0] c, input logic [23:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            burst_left = $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        op            <= o;
        encoder_count <= c;
        target        <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        if (o == OP_TICK)
            enc = c;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [29:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        if (idx == REG_STOP_BAND)
            band_cfg = d[7:0];
        if (idx == REG_SETTLE_TICKS)
            settle_cfg = d[15:0];
        @(negedge clk);
    endtask

    task automatic load_gains(input int phase);
        logic [29:0] kp, ki, kd, sb, st, dl;
        case (phase)
            0:
            begin
                // everything at full 30 bits, beyond the narrower registers
                kp = '1;
                ki = '1;
                kd = '1;
                sb = '1;
                st = '1;
                dl = '1;
            end
            1:
            begin
                kp = '0;
                ki = '0;
                kd = '0;
                sb = 30'd1;
                st = '0;
                dl = '0;
            end
            2:
            begin
                kp = 30'(PROP_GAIN_RESET);
                ki = 30'(INTEGRAL_GAIN_RESET);
                kd = 30'($urandom_range(0, 1 << 20));
                sb = 30'd2;
                st = 30'd1;
                dl = 30'd999;
            end
            default:
            begin
                kp = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(0, 1 << 24));
                ki = ($urandom_range(0, 3) == 0) ? 30'($urandom) : 30'($urandom_range(0, 1 << 16));
                kd = ($urandom_range(0, 1) == 0) ? '0 : 30'($urandom_range(0, 1 << 24));
                sb = ($urandom_range(0, 9) == 0) ? 30'd255 : 30'($urandom_range(0, 8));
                st = 30'($urandom_range(0, 12));
                dl = 30'($urandom_range(0, 1023));
            end
        endcase
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEGRAL_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_STOP_BAND, sb);
        write_reg(REG_SETTLE_TICKS, st);
        write_reg(REG_DUTY_LIMIT, dl);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_move();
        logic [23:0]        tgt;
        logic [31:0]        aim;
        logic signed [31:0] diff;
        int                 hold;
        int                 off;
        if ($urandom_range(0, 5) == 0)
            tgt = 24'($urandom);
        else
            tgt = 24'(int'($urandom_range(0, 4000)) - 2000);
        send_beat(OP_START, $urandom, tgt);
        aim = enc - {{8{tgt[23]}}, tgt};
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 19))
                0: send_beat(OP_START, $urandom, 24'($urandom));
                1: send_beat(OP_TICK, $urandom, 24'($urandom));
                2: send_beat(OP_SPARE, $urandom, 24'($urandom));
                default:
                begin
                    diff = aim - enc;
                    send_beat(OP_TICK, enc + 32'(diff >>> 1) + 32'($urandom_range(0, 6)) - 32'd3,
                              24'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 9) == 0)
        begin
            send_beat(OP_ABORT, $urandom, 24'($urandom));
            return;
        end
        // sit mostly inside the stop band for settle_cfg beats, capped at 30, plus up to three more
        hold = ((settle_cfg < 30) ? settle_cfg : 30) + int'($urandom_range(0, 3));
        repeat (hold)
        begin
            off = (band_cfg > 1) ? int'($urandom_range(0, 2 * band_cfg - 2)) - (band_cfg - 1) : 0;
            if ($urandom_range(0, 15) == 0)
                off = band_cfg + 3;
            send_beat(OP_TICK, aim + 32'(off), 24'($urandom));
        end
        if ($urandom_range(0, 1) == 1)
            send_beat(OP_ABORT, $urandom, 24'($urandom));
    endtask

    task automatic noise_beat();
        case ($urandom_range(0, 4))
            0:       send_beat(OP_TICK, $urandom, 24'($urandom));
            1:       send_beat(OP_START, $urandom, 24'($urandom));
            2:       send_beat(OP_ABORT, $urandom, 24'($urandom));
            3:       send_beat(OP_SPARE, $urandom, 24'($urandom));
            default: send_beat(OP_TICK, enc + 32'($urandom_range(0, 8)) - 32'd4, 24'($urandom));
        endcase
    endtask

    task automatic directed();
        send_beat(OP_TICK, 32'h7FFF_FFFF, 24'($urandom));
        send_beat(OP_TICK, 32'h8000_0000, 24'($urandom));
        send_beat(OP_SPARE, $urandom, 24'($urandom));
        send_beat(OP_ABORT, $urandom, 24'($urandom));
        send_beat(OP_START, $urandom, 24'h7F_FFFF);
        send_beat(OP_START, $urandom, 24'h80_0000);
        // position wraps to the most negative value, error saturates high
        send_beat(OP_TICK, 32'h0000_0000, 24'($urandom));
        send_beat(OP_TICK, 32'h7FFF_FFFF, 24'($urandom));
        send_beat(OP_ABORT, $urandom, 24'($urandom));
        send_beat(OP_START, $urandom, 24'h80_0000);
        // error saturates low
        send_beat(OP_TICK, 32'h0000_0000, 24'($urandom));
        send_beat(OP_TICK, 32'h0000_0000, 24'($urandom));
        send_beat(OP_SPARE, $urandom, 24'($urandom));
        send_beat(OP_ABORT, $urandom, 24'($urandom));
        send_beat(OP_START, $urandom, 24'h00_0000);
        send_beat(OP_TICK, enc, 24'($urandom));
        send_beat(OP_TICK, enc - 32'd5, 24'($urandom));
        send_beat(OP_TICK, 32'hFFFF_FFFF, 24'h00_0000);
        send_beat(OP_ABORT, 32'hFFFF_FFFF, 24'hFF_FFFF);
    endtask

    initial
    begin
        int phase;
        int phase_end;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed();
        phase = 0;
        while (beats_sent < RANDOM_END)
        begin
            drain();
            load_gains(phase);
            phase_end = beats_sent + int'($urandom_range(80, 130));
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 7) == 0)
                    noise_beat();
                else
                    run_move();
            end
            phase++;
        end
        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
src/epm_pkg.sv
src/epm_output_path.sv
src/encoder_position_pid_move.sv
sim/epm_checker.sv
sim/tb.sv
